>>> rtl/assert_macros.svh
// Assertion macros shared by the bit packer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> rtl/mfbp_pkg.sv
// Types and constants of the MSB-first bit packer.
// Depends on nothing; imported by every module of the block.
package mfbp_pkg;

   localparam int unsigned FIELD_MAX = 32;
   localparam int unsigned CAP_W     = 13;
   localparam int unsigned POS_W     = 16;
   localparam int unsigned INDEX_W   = 12;
   localparam int unsigned LANES     = 4;
   localparam int unsigned WIN_W     = 40;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_PAD   = 1'b1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] value;
      logic [5:0]  width;
   } item_type;

   // Everything one input item produces, delivered later one byte per cycle while the receiver is ready.
   typedef struct packed {
      logic [LANES-1:0][7:0] bytes;
      logic [INDEX_W-1:0]    base_index;
      logic [1:0]            last_sel;
      logic                  has_bytes;
      logic                  ok;
      logic [POS_W-1:0]      bits_written;
   } bundle_type;

endpackage

>>> rtl/mfbp_in_stage.sv
// Input register of the bit packer: holds one accepted item for the core.
// Depends on mfbp_pkg.
module mfbp_in_stage
   import mfbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // field_value[31:0], field_width[37:32], zeros
   input  logic        req_tuser,   // operation
   input  logic        core_ready,
   output logic        item_valid,
   output item_type    item
);

   logic     valid_ff, valid_in;
   item_type item_ff,  item_in;
   logic     accept;

   assign req_tready = !valid_ff || core_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (valid_ff && core_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in      = 1'b1;
         item_in.op    = op_type'(req_tuser);
         item_in.value = req_tdata[31:0];
         item_in.width = req_tdata[37:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/mfbp_core.sv
// Packing core: bit position, partial byte and error flag, updated once per item.
// Depends on mfbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfbp_core
   import mfbp_pkg::*;
#(
   parameter int unsigned MAX_BYTES = 4096
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wen,
   input  logic [CAP_W-1:0] csr_wdata,
   input  logic             take,
   input  item_type         item,
   output bundle_type       bundle
);

   localparam logic [16:0] MaxBytesW = 17'(MAX_BYTES);

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       partial_ff, partial_in;
   logic             ok_ff, ok_in;

   logic [16:0]       cap_eff;
   logic [19:0]       cap_bits;
   logic [16:0]       pos_sum;
   logic [2:0]        offset;
   logic [5:0]        total;
   logic [2:0]        n_bytes;
   logic [5:0]        shift;
   logic [32:0]       mask33;
   logic [31:0]       masked;
   logic [WIN_W-1:0]  window;
   logic              bad_write;

   assign cap_in  = csr_wen ? csr_wdata : cap_ff;
   assign cap_eff = ({4'b0, cap_ff} > MaxBytesW) ? MaxBytesW : {4'b0, cap_ff};
   assign cap_bits = {cap_eff, 3'b000};

   assign offset  = pos_ff[2:0];
   assign pos_sum = {1'b0, pos_ff} + {11'b0, item.width};
   assign total   = {3'b000, offset} + item.width;
   assign n_bytes = total[5:3];
   assign shift   = 6'(6'd40 - {3'b000, offset} - item.width);
   assign mask33  = ~({33{1'b1}} << item.width);
   assign masked  = item.value & mask33[31:0];
   // Old partial bits on top, the new field right below them, zeros after.
   assign window  = {partial_ff, 32'b0} | ({8'b0, masked} << shift);

   assign bad_write = (item.width == 6'd0) || (item.width > 6'(FIELD_MAX))
                      || ({3'b000, pos_sum} > cap_bits);

   always_comb begin
      pos_in     = pos_ff;
      partial_in = partial_ff;
      ok_in      = ok_ff;
      bundle     = '0;
      if (ok_ff) begin
         if (item.op == OP_WRITE) begin
            if (bad_write) begin
               ok_in = 1'b0;
            end else begin
               pos_in = pos_sum[POS_W-1:0];
               case (n_bytes)
                  3'd0:    partial_in = window[39:32];
                  3'd1:    partial_in = window[31:24];
                  3'd2:    partial_in = window[23:16];
                  3'd3:    partial_in = window[15:8];
                  default: partial_in = window[7:0];
               endcase
               if (n_bytes != 3'd0) begin
                  bundle.has_bytes  = 1'b1;
                  bundle.last_sel   = 2'(n_bytes - 3'd1);
                  bundle.base_index = pos_ff[14:3];
                  bundle.bytes[0]   = window[39:32];
                  bundle.bytes[1]   = window[31:24];
                  bundle.bytes[2]   = window[23:16];
                  bundle.bytes[3]   = window[15:8];
               end
            end
         end else if (offset != 3'd0) begin
            bundle.has_bytes  = 1'b1;
            bundle.base_index = pos_ff[14:3];
            bundle.bytes[0]   = partial_ff;
            partial_in        = 8'd0;
            pos_in            = {13'(pos_ff[15:3] + 13'd1), 3'b000};
         end
      end
      bundle.ok           = ok_in;
      bundle.bits_written = pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= '0;
         pos_ff     <= '0;
         partial_ff <= '0;
         ok_ff      <= 1'b1;
      end else begin
         cap_ff <= cap_in;
         if (take) begin
            pos_ff     <= pos_in;
            partial_ff <= partial_in;
            ok_ff      <= ok_in;
         end
      end
   end

   // The bits of the partial byte that have not been written yet must be zero.
   `ASSERT_CLK(a_partial_clean, clock, reset, (partial_ff & (8'hFF >> offset)) == 8'd0)
   `ASSERT_CLK(a_error_sticky, clock, reset, !ok_ff |=> !ok_ff)
   `ASSERT_CLK(a_frozen_on_error, clock, reset,
               (!ok_ff && take) |=> ($stable(pos_ff) && $stable(partial_ff)))

endmodule

>>> rtl/mfbp_out_stage.sv
// Result register: holds one item's bundle and hands out its results one per cycle while rsp_tready is high.
// Depends on mfbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfbp_out_stage
   import mfbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  bundle_type  bundle,
   output logic        load_ready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_byte[7:0], byte_index[19:8], ok[20],
                                    // bits_written[36:21], zeros
   output logic        rsp_tuser,   // byte_valid
   output logic        rsp_tlast    // last
);

   bundle_type         bundle_ff, bundle_in;
   logic               valid_ff,  valid_in;
   logic [1:0]         sel_ff,    sel_in;
   logic               at_last;
   logic [7:0]         cur_byte;
   logic [INDEX_W-1:0] cur_index;

   assign at_last    = (sel_ff == bundle_ff.last_sel);
   assign load_ready = !valid_ff || (rsp_tready && at_last);

   always_comb begin
      valid_in  = valid_ff;
      sel_in    = sel_ff;
      bundle_in = bundle_ff;
      if (valid_ff && rsp_tready) begin
         if (at_last) begin
            valid_in = 1'b0;
            sel_in   = 2'd0;
         end else begin
            sel_in = sel_ff + 2'd1;
         end
      end
      if (load) begin
         valid_in  = 1'b1;
         bundle_in = bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
      bundle_ff <= bundle_in;
   end

   assign cur_byte  = bundle_ff.has_bytes ? bundle_ff.bytes[sel_ff] : 8'd0;
   assign cur_index = bundle_ff.has_bytes
                      ? INDEX_W'(bundle_ff.base_index + {10'b0, sel_ff}) : '0;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000, bundle_ff.bits_written, bundle_ff.ok, cur_index, cur_byte};
   assign rsp_tuser  = bundle_ff.has_bytes;
   assign rsp_tlast  = at_last;

   `ASSERT_CLK(a_sel_holds, clock, reset, (valid_ff && !rsp_tready) |=> $stable(sel_ff))
   `ASSERT_CLK(a_status_single, clock, reset,
               (valid_ff && !bundle_ff.has_bytes) |-> (bundle_ff.last_sel == 2'd0))

endmodule

>>> rtl/msb_first_bit_packer.sv
// MSB-first bit packer. Fields of 1 to 32 bits are appended, first bit first, to a
// byte stream limited to min(capacity, MAX_BYTES) bytes; every completed byte comes
// out as one result with its index, and an item that completes no byte gives a single
// status result. An item is held in the input register and packed on its way into
// the result register, from which its results are taken. The result register delivers
// one result per cycle while rsp_tready is high, and an item has 1 to 4 results; a new
// item is taken in the cycle its predecessor's last result leaves.
// A bad width or a field past capacity clears ok for good; later items are ignored.
// Depends on mfbp_pkg, mfbp_in_stage, mfbp_core and mfbp_out_stage.
module msb_first_bit_packer
   import mfbp_pkg::*;
#(
   parameter int unsigned MAX_BYTES = 4096
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [12:0] csr_wdata,    // byte_capacity
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,    // field_value[31:0], field_width[37:32], zeros
   input  logic        req_tuser,    // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // out_byte[7:0], byte_index[19:8], ok[20],
                                     // bits_written[36:21], zeros
   output logic        rsp_tuser,    // byte_valid
   output logic        rsp_tlast     // last
);

   logic       core_ready;
   logic       item_valid;
   logic       take;
   item_type   item;
   bundle_type bundle;

   assign take = item_valid && core_ready;

   mfbp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .core_ready (core_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   mfbp_core #(
      .MAX_BYTES (MAX_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .take      (take),
      .item      (item),
      .bundle    (bundle)
   );

   mfbp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .bundle     (bundle),
      .load_ready (core_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> verif/tb_msb_first_bit_packer.sv
// Self-checking testbench for msb_first_bit_packer: directed and random fields and pads,
// capacity changes between phases, random idling on both streams, one sticky error at the end.
// Depends on mfbp_pkg and the msb_first_bit_packer RTL.
module tb_msb_first_bit_packer
   import mfbp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned BUF_BYTES = 4096;

   typedef struct packed {
      logic [7:0]  data;
      logic [11:0] index;
      logic        valid;
      logic        last;
      logic        ok;
      logic [15:0] bits;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [12:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;     // field_value[31:0], field_width[37:32], zeros
   logic        req_tuser = 1'b0;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // out_byte[7:0], byte_index[19:8], ok[20],
                                   // bits_written[36:21], zeros
   logic        rsp_tuser;         // byte_valid
   logic        rsp_tlast;

   // Packer state as the testbench expects it to be.
   int unsigned capacity = 0;
   int unsigned bit_pos = 0;
   logic [7:0]  partial = '0;
   logic        ok_now = 1'b1;

   item_type    fields_to_send[$];
   result_type  bytes_due[$];
   item_type    offered;
   bit          sending = 1'b0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          fail_count = 0;
   result_type  want;

   msb_first_bit_packer #(.MAX_BYTES(BUF_BYTES)) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("tb_msb_first_bit_packer: done, errors");
      $finish;
   end

   function automatic int draw_wait(input int pct);
      if ($urandom_range(0, 99) < pct)
         return $urandom_range(0, 16);
      return 0;
   endfunction

   // Appends one field or pad to the expected byte stream.
   task automatic pack_bits(input item_type it);
      result_type  staged[$];
      result_type  r;
      int unsigned cap_bits;
      cap_bits = ((capacity > BUF_BYTES) ? BUF_BYTES : capacity) * 8;
      if (ok_now) begin
         if (it.op == OP_WRITE) begin
            if (it.width == 0 || it.width > FIELD_MAX || bit_pos + it.width > cap_bits) begin
               ok_now = 1'b0;
            end else begin
               for (int i = it.width - 1; i >= 0; i--) begin
                  partial[7 - (bit_pos % 8)] = it.value[i];
                  bit_pos++;
                  if (bit_pos % 8 == 0) begin
                     r = '0;
                     r.data = partial;
                     r.index = 12'(bit_pos / 8 - 1);
                     r.valid = 1'b1;
                     staged.push_back(r);
                     partial = '0;
                  end
               end
            end
         end else if (bit_pos % 8 != 0) begin
            r = '0;
            r.data = partial;
            r.index = 12'(bit_pos / 8);
            r.valid = 1'b1;
            staged.push_back(r);
            partial = '0;
            bit_pos = (bit_pos + 7) & ~32'd7;
         end
      end
      // An item that completes no byte still reports its status.
      if (staged.size() == 0)
         staged.push_back('0);
      foreach (staged[k]) begin
         staged[k].last = (k == staged.size() - 1);
         staged[k].ok = ok_now;
         staged[k].bits = bit_pos[15:0];
         bytes_due.push_back(staged[k]);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         fail_count++;
         $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
      end
   endtask

   // Sender: one item at a time from the pending queue, with a random gap before each.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         sending = 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pack_bits(offered);
            sending = 1'b0;
            send_gap = draw_wait(send_idle_pct);
         end
         if (!sending) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (fields_to_send.size() != 0) begin
               offered = fields_to_send.pop_front();
               sending = 1'b1;
               req_tdata <= {2'b00, offered.width, offered.value};
               req_tuser <= offered.op;
            end
         end
         req_tvalid <= sending;
      end
   end

   // Receiver: checks each result against the oldest expected one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (bytes_due.size() == 0) begin
               fail_count++;
               $display("%0t: result with none expected, expected nothing, got tdata %h",
                        $time, rsp_tdata);
            end else begin
               want = bytes_due.pop_front();
               check_field("out_byte", want.data, rsp_tdata[7:0]);
               check_field("byte_index", want.index, rsp_tdata[19:8]);
               check_field("ok", want.ok, rsp_tdata[20]);
               check_field("bits_written", want.bits, rsp_tdata[36:21]);
               check_field("byte_valid", want.valid, rsp_tuser);
               check_field("last", want.last, rsp_tlast);
            end
            stall_left = draw_wait(recv_idle_pct);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send(input op_type op, input logic [31:0] value, input logic [5:0] width);
      item_type it;
      it.op = op;
      it.value = value;
      it.width = width;
      fields_to_send.push_back(it);
   endtask

   task automatic send_random(input int count);
      logic [5:0] w;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0: send(OP_PAD, $urandom, 6'($urandom_range(0, 63)));
            1: send(OP_WRITE, $urandom, 6'(FIELD_MAX));
            2: send(OP_WRITE, $urandom, 6'd1);
            default: begin
               w = 6'($urandom_range(1, FIELD_MAX));
               send(OP_WRITE, $urandom, w);
            end
         endcase
      end
   endtask

   // Returns once every item has been taken and every result has come back.
   task automatic wait_idle();
      while (fields_to_send.size() != 0 || sending || bytes_due.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [12:0] bytes_n);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= bytes_n;
      @(posedge clock);
      csr_wen <= 1'b0;
      capacity = bytes_n;
   endtask

   initial begin
      int unsigned fit_bits;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Capacity is zero after reset, so only pads can go through.
      send(OP_PAD, 32'h0, 6'd0);
      send(OP_PAD, 32'hFFFF_FFFF, 6'd63);
      wait_idle();
      set_capacity(13'h1FFF);

      send(OP_WRITE, 32'h1, 6'd1);
      send(OP_PAD, 32'h0, 6'd0);
      send(OP_PAD, 32'h0, 6'd0);
      send(OP_WRITE, 32'hFFFF_FFFF, 6'd32);
      send(OP_WRITE, 32'h0, 6'd32);
      send(OP_WRITE, 32'h0000_00A5, 6'd8);
      send(OP_WRITE, 32'hFFFF_FFFF, 6'd3);
      send(OP_WRITE, 32'hDEAD_BEEF, 6'd32);
      send(OP_WRITE, 32'h0001_FFFF, 6'd13);
      send(OP_WRITE, 32'h5, 6'd5);
      send(OP_PAD, 32'hFFFF_FFFF, 6'd32);
      send(OP_WRITE, 32'h8000_0001, 6'd16);
      send(OP_WRITE, 32'h0, 6'd1);
      send(OP_WRITE, 32'h8000_0001, 6'd32);
      send(OP_WRITE, 32'h7FFF_FFFF, 6'd31);
      send(OP_WRITE, 32'hFFFF_FFFE, 6'd32);
      send(OP_PAD, 32'h0, 6'd0);
      wait_idle();

      set_capacity(13'(BUF_BYTES));
      send_idle_pct = 30;
      recv_idle_pct = 30;
      send_random(30);
      wait_idle();

      // Shrink the capacity to just past the position and fill it to the last bit.
      set_capacity(13'(bit_pos / 8 + 2));
      fit_bits = capacity * 8 - bit_pos;
      send(OP_WRITE, $urandom, 6'(fit_bits - 8));
      send(OP_WRITE, $urandom, 6'd8);
      send(OP_PAD, $urandom, 6'd0);
      wait_idle();

      set_capacity(13'($urandom_range(bit_pos / 8 + 400, 13'h1FFF)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(30);
      wait_idle();
      send_idle_pct = 80;
      recv_idle_pct = 20;
      send_random(25);
      send_idle_pct = 10;
      recv_idle_pct = 80;
      send_random(25);
      wait_idle();

      // One sticky error; everything after it must be ignored.
      send_idle_pct = 30;
      recv_idle_pct = 30;
      case ($urandom_range(0, 3))
         0: send(OP_WRITE, $urandom, 6'd0);
         1: send(OP_WRITE, $urandom, 6'($urandom_range(33, 63)));
         2: begin
            set_capacity(13'(bit_pos / 8 + 1));
            send(OP_WRITE, $urandom, 6'd32);
         end
         default: begin
            // Capacity below the current position: pads still work, writes fail.
            set_capacity(13'(bit_pos / 8 - 1));
            send(OP_PAD, $urandom, 6'd0);
            send(OP_WRITE, $urandom, 6'd1);
         end
      endcase
      repeat (25) send($urandom_range(0, 1) ? OP_PAD : OP_WRITE, $urandom,
                       6'($urandom_range(0, 63)));
      wait_idle();
      repeat (10) @(posedge clock);

      if (fail_count == 0)
         $display("tb_msb_first_bit_packer: done, clean");
      else
         $display("tb_msb_first_bit_packer: done, errors");
      $finish;
   end

endmodule
